[sv/bcis_pkg.sv]
package bcis_pkg;

	localparam int COORD_W   = 18;
	localparam int COL_W     = 13;
	localparam int SCORE_W   = 25;
	localparam logic [SCORE_W-1:0] SCORE_MAX = 25'h1FFFFFF;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_SCORE = 1'b1;

	localparam logic [1:0] REG_COLS   = 2'd0;
	localparam logic [1:0] REG_ROWS   = 2'd1;
	localparam logic [1:0] REG_WINDOW = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_WAIT,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} bcis_state_t;

	typedef struct packed {
		logic                      done;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} eval_sts_t;

endpackage

[sv/bcis_ram.sv]
module bcis_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[sv/bcis_eval.sv]
module bcis_eval import bcis_pkg::*; #(
	parameter int SAMPLE_STEPS = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                load,
	input  logic signed [15:0]                  p0_x,
	input  logic signed [15:0]                  p0_y,
	input  logic signed [15:0]                  p1_x,
	input  logic signed [15:0]                  p1_y,
	input  logic signed [15:0]                  p2_x,
	input  logic signed [15:0]                  p2_y,
	input  logic signed [15:0]                  p3_x,
	input  logic signed [15:0]                  p3_y,
	input  logic                                start,
	input  logic [$clog2(SAMPLE_STEPS):0]       k,
	output eval_sts_t                           sts
);

	localparam int SL  = $clog2(SAMPLE_STEPS);
	localparam int KW  = SL + 1;
	localparam int CW  = 20;
	localparam int H1W = 40;
	localparam int H2W = 56;
	localparam int H3W = 64;
	localparam int SH  = 3 * SL + 4;

	logic signed [CW-1:0]  c_q   [2][4];
	logic signed [CW-1:0]  c_d   [2][4];
	logic signed [15:0]    pt    [2][4];
	logic [KW-1:0]         k_q;
	logic [4:0]            v_q;
	logic signed [H1W-1:0] h1_s1 [2];
	logic signed [H2W-1:0] h2_s2 [2];
	logic signed [H3W-1:0] h3_s3 [2];
	logic signed [COORD_W-1:0] r_s4 [2];
	logic signed [KW:0]    ks;

	assign ks = $signed({1'b0, k_q});

	always_comb begin
		pt[0][0] = p0_x; pt[0][1] = p1_x; pt[0][2] = p2_x; pt[0][3] = p3_x;
		pt[1][0] = p0_y; pt[1][1] = p1_y; pt[1][2] = p2_y; pt[1][3] = p3_y;
		for (int l = 0; l < 2; l++) begin
			c_d[l][0] = CW'(pt[l][0]);
			c_d[l][1] = CW'(3) * (CW'(pt[l][1]) - CW'(pt[l][0]));
			c_d[l][2] = CW'(3) * (CW'(pt[l][0]) - CW'(2) * CW'(pt[l][1])
				+ CW'(pt[l][2]));
			c_d[l][3] = CW'(pt[l][3]) - CW'(3) * CW'(pt[l][2])
				+ CW'(3) * CW'(pt[l][1]) - CW'(pt[l][0]);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			c_q <= c_d;
		end
		if (start) begin
			k_q <= k;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[3:0], start};
		end
	end

	for (genvar l = 0; l < 2; l++) begin : g_lane
		logic signed [CW+KW:0]  m1;
		logic signed [H1W+KW:0] m2;
		logic signed [H2W+KW:0] m3;
		logic [H3W-1:0]         mag;
		logic [H3W-1:0]         rnd;

		assign m1  = c_q[l][3] * ks;
		assign m2  = h1_s1[l] * ks;
		assign m3  = h2_s2[l] * ks;
		assign mag = h3_s3[l][H3W-1] ? H3W'(-h3_s3[l]) : H3W'(h3_s3[l]);
		assign rnd = (mag + (H3W'(1) << (SH - 1))) >> SH;

		always_ff @(posedge clk) begin
			h1_s1[l] <= H1W'(m1) + (H1W'(c_q[l][2]) <<< SL);
			h2_s2[l] <= H2W'(m2) + (H2W'(c_q[l][1]) <<< (2 * SL));
			h3_s3[l] <= H3W'(m3) + (H3W'(c_q[l][0]) <<< (3 * SL));
			r_s4[l]  <= h3_s3[l][H3W-1] ? -$signed(rnd[COORD_W-1:0])
				: $signed(rnd[COORD_W-1:0]);
		end
	end

	assign sts.done = v_q[4];
	assign sts.x    = r_s4[0];
	assign sts.y    = r_s4[1];

endmodule

[sv/bezier_curve_image_score.sv]
// Scores cubic Bezier curves against an 8-bit grey image held in one on-chip
// memory of MAX_ROWS x MAX_COLS pixels. A write transfer (opcode 0) stores one
// pixel; pixels outside image_cols x image_rows are dropped. A score transfer
// (opcode 1) evaluates the curve at SAMPLE_STEPS+1 points and returns one
// curve_score, the saturated sum of the window pixels along it. Every pixel
// the curve touches must have been written first. Each point of a score has a
// launch step, then Horner evaluation and rounding; for each point inside the
// image whose window is not empty, the window pixels are read one after
// another through the single read port of the image memory, then a drain
// step follows. At the end the result is handed to the output register. One
// item is worked on at a time; a finished score waits in the output register
// while the next transfer is taken.
module bezier_curve_image_score import bcis_pkg::*; #(
	parameter int MAX_COLS     = 512,
	parameter int MAX_ROWS     = 256,
	parameter int SAMPLE_STEPS = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               opcode,
	input  logic [7:0]         pixel_row,
	input  logic [8:0]         pixel_col,
	input  logic [7:0]         pixel_value,
	input  logic signed [15:0] p0_x,
	input  logic signed [15:0] p0_y,
	input  logic signed [15:0] p1_x,
	input  logic signed [15:0] p1_y,
	input  logic signed [15:0] p2_x,
	input  logic signed [15:0] p2_y,
	input  logic signed [15:0] p3_x,
	input  logic signed [15:0] p3_y,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [24:0]        curve_score,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [9:0]         cfg_data
);

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = $clog2(DEPTH);
	localparam int KW    = $clog2(SAMPLE_STEPS) + 1;

	bcis_state_t        state_q, state_d;
	eval_sts_t          sts;
	logic [9:0]         cols_q;
	logic [8:0]         rows_q;
	logic [5:0]         hw_q;
	logic [COL_W-1:0]   cols_e, rows_e;
	logic               in_acc, score_acc, wr_en;
	logic [AW-1:0]      wr_addr, rd_addr;
	logic [7:0]         rd_data;
	logic               rd_en, rd_v_s1;
	logic [KW-1:0]      k_q;
	logic               last_k, k_inc, start, scan_go, out_load;
	logic [COL_W-1:0]   a_q, hi_q, row_q;
	logic [COL_W-1:0]   xu, yu, lo_c, hi_c, xw;
	logic               inb;
	logic [SCORE_W-1:0] acc_q, score_q;
	logic               out_valid_q;
	logic [SCORE_W:0]   sum;

	assign cols_e = (COL_W'(cols_q) > COL_W'(MAX_COLS)) ? COL_W'(MAX_COLS) : COL_W'(cols_q);
	assign rows_e = (COL_W'(rows_q) > COL_W'(MAX_ROWS)) ? COL_W'(MAX_ROWS) : COL_W'(rows_q);

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= 10'd512;
			rows_q <= 9'd256;
			hw_q   <= 6'd10;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_COLS:   cols_q <= cfg_data;
				REG_ROWS:   rows_q <= cfg_data[8:0];
				REG_WINDOW: hw_q   <= cfg_data[5:0];
				default:    ;
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign score_acc = in_acc && (opcode == OP_SCORE);
	assign wr_en     = in_acc && (opcode == OP_WRITE) && (COL_W'(pixel_row) < rows_e)
		&& (COL_W'(pixel_col) < cols_e);
	assign wr_addr   = AW'(32'(pixel_row) * 32'(MAX_COLS) + 32'(pixel_col));
	assign rd_addr   = AW'(32'(row_q) * 32'(MAX_COLS) + 32'(a_q));

	bcis_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (pixel_value),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	bcis_eval #(.SAMPLE_STEPS(SAMPLE_STEPS)) u_eval (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (score_acc),
		.p0_x   (p0_x),
		.p0_y   (p0_y),
		.p1_x   (p1_x),
		.p1_y   (p1_y),
		.p2_x   (p2_x),
		.p2_y   (p2_y),
		.p3_x   (p3_x),
		.p3_y   (p3_y),
		.start  (start),
		.k      (k_q),
		.sts    (sts)
	);

	assign inb = (sts.x > 18'sd0) && (sts.x < $signed(COORD_W'(cols_e)))
		&& (sts.y > 18'sd0) && (sts.y < $signed(COORD_W'(rows_e)));
	assign xu      = sts.x[COL_W-1:0];
	assign yu      = sts.y[COL_W-1:0];
	assign xw      = xu + COL_W'(hw_q);
	assign lo_c    = (xu > COL_W'(hw_q)) ? xu - COL_W'(hw_q) : '0;
	assign hi_c    = (xw > cols_e) ? cols_e : xw;
	assign scan_go = inb && (lo_c < hi_c);
	assign last_k  = (k_q == KW'(SAMPLE_STEPS));

	always_comb begin
		state_d  = state_q;
		start    = 1'b0;
		rd_en    = 1'b0;
		k_inc    = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (score_acc) state_d = ST_START;
			end
			ST_START: begin
				start   = 1'b1;
				state_d = ST_WAIT;
			end
			ST_WAIT: begin
				if (sts.done) begin
					if (scan_go) begin
						state_d = ST_SCAN;
					end else begin
						k_inc   = !last_k;
						state_d = last_k ? ST_DONE : ST_START;
					end
				end
			end
			ST_SCAN: begin
				rd_en = 1'b1;
				if (a_q == hi_q - COL_W'(1)) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				k_inc   = !last_k;
				state_d = last_k ? ST_DONE : ST_START;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= rd_en;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sum = {1'b0, acc_q} + (SCORE_W + 1)'(rd_data);

	always_ff @(posedge clk) begin
		if (score_acc) begin
			k_q <= '0;
		end else if (k_inc) begin
			k_q <= k_q + KW'(1);
		end
		if (score_acc) begin
			acc_q <= '0;
		end else if (rd_v_s1) begin
			acc_q <= (sum > (SCORE_W + 1)'(SCORE_MAX)) ? SCORE_MAX : sum[SCORE_W-1:0];
		end
		if (state_q == ST_WAIT && sts.done) begin
			a_q   <= lo_c;
			hi_q  <= hi_c;
			row_q <= yu;
		end else if (rd_en) begin
			a_q <= a_q + COL_W'(1);
		end
		if (out_load) begin
			score_q <= acc_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign curve_score = score_q;

	a_read_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_v_s1 |-> $past(state_q == ST_SCAN))
		else $error("read data without a scan cycle");

	a_eval_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sts.done |-> state_q == ST_WAIT)
		else $error("curve point finished outside wait");

	a_no_read_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !rd_en)
		else $error("image read while idle");

endmodule
